[hw/rtl/qs_pkg.sv]
// shared constants, types and tables of the quaternion slerp block
package qs_pkg;

    localparam int FRAC_BITS    = 14;
    localparam int CORDIC_STEPS = 16;
    localparam int W_W          = FRAC_BITS + 1;
    localparam int SQ_STEPS     = 31;
    localparam int QD           = 4;
    localparam int QPTR_W       = 2;
    localparam int QCNT_W       = 3;
    localparam int ADDR_W       = 3;

    localparam logic [W_W-1:0]    W_ONE       = W_W'(64'd1 << FRAC_BITS);
    localparam logic [14:0]       ONE_Q14     = 15'd16384;
    localparam logic [30:0]       HALF_PI_Q30 = 31'd1686629713;
    localparam logic [14:0]       THR_RESET   = 15'd16302;
    localparam logic [ADDR_W-3:0] REG_THR     = '0;

    typedef struct packed {
        logic [3:0][16:0] a;
        logic [3:0][15:0] b;
        logic [14:0]      t;
        logic [28:0]      dot;
        logic             linear;
    } qs_item_t;

    typedef struct packed {
        logic              full;
        logic              empty;
        logic [QCNT_W-1:0] count;
    } qs_qstat_t;

    function automatic logic [29:0] atan_q30(input logic [4:0] i);
        logic [29:0] v;
        begin
            case (i)
                5'd0:    v = 30'd843314857;
                5'd1:    v = 30'd497837829;
                5'd2:    v = 30'd263043837;
                5'd3:    v = 30'd133525159;
                5'd4:    v = 30'd67021687;
                5'd5:    v = 30'd33543516;
                5'd6:    v = 30'd16775851;
                5'd7:    v = 30'd8388437;
                5'd8:    v = 30'd4194283;
                5'd9:    v = 30'd2097149;
                5'd10:   v = 30'd1048576;
                5'd11:   v = 30'd524288;
                5'd12:   v = 30'd262144;
                5'd13:   v = 30'd131072;
                5'd14:   v = 30'd65536;
                5'd15:   v = 30'd32768;
                5'd16:   v = 30'd16384;
                5'd17:   v = 30'd8192;
                5'd18:   v = 30'd4096;
                5'd19:   v = 30'd2048;
                5'd20:   v = 30'd1024;
                5'd21:   v = 30'd512;
                5'd22:   v = 30'd256;
                5'd23:   v = 30'd128;
                5'd24:   v = 30'd64;
                5'd25:   v = 30'd32;
                5'd26:   v = 30'd16;
                5'd27:   v = 30'd8;
                5'd28:   v = 30'd4;
                5'd29:   v = 30'd2;
                5'd30:   v = 30'd1;
                default: v = 30'd0;
            endcase
            return v;
        end
    endfunction

    // rescale a q14 weight to the weight format
    function automatic logic [W_W-1:0] q14_to_w(input logic [14:0] v);
        int          up;
        int          down;
        logic [63:0] e;
        begin
            up   = (FRAC_BITS >= 14) ? FRAC_BITS - 14 : 0;
            down = (FRAC_BITS < 14) ? 14 - FRAC_BITS : 0;
            e    = 64'(v);
            return W_W'((e << up) >> down);
        end
    endfunction

endpackage

[hw/rtl/qs_front.sv]
// front end: dot product, hemisphere fold, clamp and path select
module qs_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  logic [15:0]      a_x,
    input  logic [15:0]      a_y,
    input  logic [15:0]      a_z,
    input  logic [15:0]      a_w,
    input  logic [15:0]      b_x,
    input  logic [15:0]      b_y,
    input  logic [15:0]      b_z,
    input  logic [15:0]      b_w,
    input  logic [14:0]      blend,
    input  logic [14:0]      thr,
    output logic             push,
    output qs_pkg::qs_item_t item
);
    import qs_pkg::*;

    logic               vld_reg;
    logic signed [31:0] prod_reg [4];
    logic [15:0]        a_reg [4];
    logic [15:0]        b_reg [4];
    logic [14:0]        t_reg;

    logic [15:0]        a_in [4];
    logic [15:0]        b_in [4];
    logic signed [33:0] sum;
    logic signed [33:0] mag;
    logic               neg;
    logic [28:0]        dotc;

    assign a_in[0] = a_x;
    assign a_in[1] = a_y;
    assign a_in[2] = a_z;
    assign a_in[3] = a_w;
    assign b_in[0] = b_x;
    assign b_in[1] = b_y;
    assign b_in[2] = b_z;
    assign b_in[3] = b_w;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 4; k++)
        begin
            prod_reg[k] <= $signed(a_in[k]) * $signed(b_in[k]);
            a_reg[k]    <= a_in[k];
            b_reg[k]    <= b_in[k];
        end
        t_reg <= (blend > ONE_Q14) ? ONE_Q14 : blend;
    end

    always_comb
    begin
        sum = 34'(prod_reg[0]) + 34'(prod_reg[1]) + 34'(prod_reg[2]) + 34'(prod_reg[3]);
        neg = sum < 0;
        mag = neg ? -sum : sum;
        dotc = (mag > 34'sd268435456) ? 29'd268435456 : mag[28:0];
        for (int k = 0; k < 4; k++)
        begin
            // fold to the short arc: all four components of a flip
            item.a[k] = neg ? 17'(-$signed(17'($signed(a_reg[k]))))
                            : 17'($signed(a_reg[k]));
            item.b[k] = b_reg[k];
        end
        item.t      = t_reg;
        item.dot    = dotc;
        item.linear = dotc >= {thr, 14'd0};
    end

    assign push = vld_reg;

endmodule

[hw/rtl/qs_queue.sv]
// short word queue between the front end and the blend pipeline
module qs_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  qs_pkg::qs_item_t  item_in,
    input  logic              pop,
    output qs_pkg::qs_item_t  item_out,
    output qs_pkg::qs_qstat_t status
);
    import qs_pkg::*;

    qs_item_t          mem_reg [QD];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= item_in;
        end
    end

    assign item_out     = mem_reg[rd_ptr_reg];
    assign status.count = count_reg;
    assign status.empty = count_reg == '0;
    assign status.full  = count_reg == QCNT_W'(QD);

endmodule

[hw/rtl/qs_back.sv]
// blend pipeline: isqrt, acos cordic, sine cordics, weight division, mix
module qs_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_vld,
    input  qs_pkg::qs_item_t in_item,
    output logic             done,
    output logic [15:0]      out_x,
    output logic [15:0]      out_y,
    output logic [15:0]      out_z,
    output logic [15:0]      out_w,
    output logic             used_linear
);
    import qs_pkg::*;

    localparam int CS      = CORDIC_STEPS;
    localparam int SQ_END  = SQ_STEPS;
    localparam int VEC_END = SQ_END + CS;
    localparam int CLP     = VEC_END + 1;
    localparam int MUL     = CLP + 1;
    localparam int ROT_END = MUL + CS;
    localparam int DSU     = ROT_END + 1;
    localparam int DIV_END = DSU + W_W;
    localparam int WGT     = DIV_END + 1;
    localparam int PRD     = WGT + 1;
    localparam int BL      = PRD + 1;
    localparam int REM_W   = 32 + FRAC_BITS;
    localparam int PA_W    = W_W + 18;
    localparam int PB_W    = W_W + 17;
    localparam int ACC_W   = W_W + 19;

    logic [BL-1:0]       vld_reg;
    logic [BL-1:0]       vld_next;
    qs_item_t            side_reg [BL];
    qs_item_t            side_next [BL];

    logic [60:0]         sqv_reg [SQ_STEPS+1];
    logic [60:0]         sqv_next [SQ_STEPS+1];
    logic [61:0]         sqr_reg [SQ_STEPS+1];
    logic [61:0]         sqr_next [SQ_STEPS+1];

    logic signed [34:0]  vx_reg [CS];
    logic signed [34:0]  vx_next [CS];
    logic signed [34:0]  vy_reg [CS];
    logic signed [34:0]  vy_next [CS];
    logic signed [32:0]  vz_reg [CS];
    logic signed [32:0]  vz_next [CS];
    logic [CS-1:0]       zf_reg;
    logic [CS-1:0]       zf_next;

    logic [30:0]         theta_reg;
    logic [30:0]         theta_next;
    logic [30:0]         ang_reg [3];
    logic [30:0]         ang_next [3];

    logic signed [33:0]  rx_reg [3][CS];
    logic signed [33:0]  rx_next [3][CS];
    logic signed [33:0]  ry_reg [3][CS];
    logic signed [33:0]  ry_next [3][CS];
    logic signed [32:0]  rz_reg [3][CS];
    logic signed [32:0]  rz_next [3][CS];

    logic [REM_W-1:0]    rem_reg [2][W_W+1];
    logic [REM_W-1:0]    rem_next [2][W_W+1];
    logic [W_W-1:0]      q_reg [2][W_W+1];
    logic [W_W-1:0]      q_next [2][W_W+1];
    logic [30:0]         den_reg [W_W+1];
    logic [30:0]         den_next [W_W+1];
    logic [1:0]          pos_reg [W_W+1];
    logic [1:0]          pos_next [W_W+1];
    logic [1:0]          sat_reg [W_W+1];
    logic [1:0]          sat_next [W_W+1];

    logic [W_W-1:0]      wa_reg;
    logic [W_W-1:0]      wa_next;
    logic [W_W-1:0]      wb_reg;
    logic [W_W-1:0]      wb_next;
    logic signed [PA_W-1:0] pra_reg [4];
    logic signed [PA_W-1:0] pra_next [4];
    logic signed [PB_W-1:0] prb_reg [4];
    logic signed [PB_W-1:0] prb_next [4];

    logic [15:0]         out_reg [4];
    logic [15:0]         out_next [4];
    logic                done_reg;
    logic                lin_out_reg;

    logic [57:0]         dsq;
    logic [61:0]         bitv;
    logic [61:0]         trial;
    logic signed [34:0]  cx;
    logic signed [34:0]  cy;
    logic signed [34:0]  dx;
    logic signed [34:0]  dy;
    logic signed [32:0]  cz;
    logic signed [32:0]  at_s;
    logic                czf;
    logic signed [33:0]  ex;
    logic signed [33:0]  ey;
    logic signed [33:0]  ddx;
    logic signed [33:0]  ddy;
    logic signed [32:0]  ez;
    logic signed [32:0]  zc;
    logic [45:0]         prod_pa;
    logic [45:0]         prod_pb;
    logic [14:0]         tcl;
    logic signed [33:0]  s0;
    logic signed [33:0]  num;
    logic                s0pos;
    logic [REM_W-1:0]    rem0;
    logic [REM_W:0]      sat_lim;
    logic [REM_W-1:0]    sub;
    logic [W_W-1:0]      sph [2];
    logic signed [ACC_W-1:0] acc;
    logic signed [ACC_W-1:0] rr;

    always_comb
    begin
        vld_next[0]  = in_vld;
        side_next[0] = in_item;
        for (int k = 1; k < BL; k++)
        begin
            vld_next[k]  = vld_reg[k-1];
            side_next[k] = side_reg[k-1];
        end

        // isqrt of 1 - d^2, one result bit per stage
        dsq         = in_item.dot * in_item.dot;
        sqv_next[0] = 61'(62'd1 << 60) - 61'({dsq, 4'd0});
        sqr_next[0] = '0;
        for (int j = 0; j < SQ_STEPS; j++)
        begin
            bitv  = 62'd1 << (2 * (SQ_STEPS - 1 - j));
            trial = sqr_reg[j] + bitv;
            if ({1'b0, sqv_reg[j]} >= trial)
            begin
                sqv_next[j+1] = sqv_reg[j] - trial[60:0];
                sqr_next[j+1] = (sqr_reg[j] >> 1) + bitv;
            end
            else
            begin
                sqv_next[j+1] = sqv_reg[j];
                sqr_next[j+1] = sqr_reg[j] >> 1;
            end
        end

        // vectoring cordic gives acos as atan2(sqrt(1-d^2), d)
        for (int j = 0; j < CS; j++)
        begin
            if (j == 0)
            begin
                cx  = 35'({side_reg[SQ_END].dot, 2'b00});
                cy  = 35'(sqr_reg[SQ_END]);
                cz  = '0;
                czf = sqr_reg[SQ_END] == '0;
            end
            else
            begin
                cx  = vx_reg[j-1];
                cy  = vy_reg[j-1];
                cz  = vz_reg[j-1];
                czf = zf_reg[j-1];
            end
            dx   = cy >>> j;
            dy   = cx >>> j;
            at_s = $signed({3'b000, atan_q30(5'(j))});
            if (cy > 0)
            begin
                vx_next[j] = cx + dx;
                vy_next[j] = cy - dy;
                vz_next[j] = cz + at_s;
            end
            else
            begin
                vx_next[j] = cx - dx;
                vy_next[j] = cy + dy;
                vz_next[j] = cz - at_s;
            end
            zf_next[j] = czf;
        end

        zc = vz_reg[CS-1];
        if (zf_reg[CS-1] || zc < 0)
        begin
            theta_next = '0;
        end
        else if (zc > $signed({2'b00, HALF_PI_Q30}))
        begin
            theta_next = HALF_PI_Q30;
        end
        else
        begin
            theta_next = zc[30:0];
        end

        tcl         = side_reg[CLP].t;
        prod_pa     = theta_reg * (ONE_Q14 - tcl);
        prod_pb     = theta_reg * tcl;
        ang_next[0] = theta_reg;
        ang_next[1] = prod_pa[44:14];
        ang_next[2] = prod_pb[44:14];

        // three rotation cordics: sin(theta), sin((1-t)theta), sin(t theta)
        for (int l = 0; l < 3; l++)
        begin
            for (int j = 0; j < CS; j++)
            begin
                if (j == 0)
                begin
                    ex = 34'sd1 <<< 30;
                    ey = '0;
                    ez = $signed({2'b00, ang_reg[l]});
                end
                else
                begin
                    ex = rx_reg[l][j-1];
                    ey = ry_reg[l][j-1];
                    ez = rz_reg[l][j-1];
                end
                ddx  = ey >>> j;
                ddy  = ex >>> j;
                at_s = $signed({3'b000, atan_q30(5'(j))});
                if (ez >= 0)
                begin
                    rx_next[l][j] = ex - ddx;
                    ry_next[l][j] = ey + ddy;
                    rz_next[l][j] = ez - at_s;
                end
                else
                begin
                    rx_next[l][j] = ex + ddx;
                    ry_next[l][j] = ey - ddy;
                    rz_next[l][j] = ez + at_s;
                end
            end
        end

        // division setup; a non-positive sin(theta) falls back to linear
        s0    = ry_reg[0][CS-1];
        s0pos = s0 > 0;
        side_next[DSU].linear = side_reg[DSU-1].linear | !s0pos;
        den_next[0] = s0[30:0];
        for (int n = 0; n < 2; n++)
        begin
            num            = ry_reg[n+1][CS-1];
            rem0           = REM_W'(num[30:0]) << FRAC_BITS;
            sat_lim        = {1'b0, REM_W'(s0[30:0]) << FRAC_BITS} + (REM_W+1)'(s0[30:0]);
            pos_next[0][n] = num > 0;
            sat_next[0][n] = {1'b0, rem0} >= sat_lim;
            rem_next[n][0] = rem0;
            q_next[n][0]   = '0;
        end

        // restoring division, one quotient bit per stage
        for (int j = 0; j < W_W; j++)
        begin
            den_next[j+1] = den_reg[j];
            pos_next[j+1] = pos_reg[j];
            sat_next[j+1] = sat_reg[j];
            sub           = REM_W'(den_reg[j]) << (FRAC_BITS - j);
            for (int n = 0; n < 2; n++)
            begin
                if (rem_reg[n][j] >= sub)
                begin
                    rem_next[n][j+1] = rem_reg[n][j] - sub;
                    q_next[n][j+1]   = q_reg[n][j] | (W_W'(1) << (FRAC_BITS - j));
                end
                else
                begin
                    rem_next[n][j+1] = rem_reg[n][j];
                    q_next[n][j+1]   = q_reg[n][j];
                end
            end
        end

        for (int n = 0; n < 2; n++)
        begin
            if (!pos_reg[W_W][n])
            begin
                sph[n] = '0;
            end
            else if (sat_reg[W_W][n])
            begin
                sph[n] = W_ONE;
            end
            else
            begin
                sph[n] = q_reg[n][W_W];
            end
        end
        if (side_reg[DIV_END].linear)
        begin
            wa_next = q14_to_w(ONE_Q14 - side_reg[DIV_END].t);
            wb_next = q14_to_w(side_reg[DIV_END].t);
        end
        else
        begin
            wa_next = sph[0];
            wb_next = sph[1];
        end

        for (int k = 0; k < 4; k++)
        begin
            pra_next[k] = $signed({1'b0, wa_reg}) * $signed(side_reg[WGT].a[k]);
            prb_next[k] = $signed({1'b0, wb_reg}) * $signed(side_reg[WGT].b[k]);
        end

        // round half up, floor shift, saturate
        for (int k = 0; k < 4; k++)
        begin
            acc = ACC_W'(pra_reg[k]) + ACC_W'(prb_reg[k])
                + $signed(ACC_W'(64'd1 << (FRAC_BITS - 1)));
            rr  = acc >>> FRAC_BITS;
            if (rr > $signed(ACC_W'(32767)))
            begin
                out_next[k] = 16'h7fff;
            end
            else if (rr < -$signed(ACC_W'(32768)))
            begin
                out_next[k] = 16'h8000;
            end
            else
            begin
                out_next[k] = rr[15:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            vld_reg  <= vld_next;
            done_reg <= vld_reg[PRD];
        end
    end

    always_ff @(posedge clk)
    begin
        side_reg    <= side_next;
        sqv_reg     <= sqv_next;
        sqr_reg     <= sqr_next;
        vx_reg      <= vx_next;
        vy_reg      <= vy_next;
        vz_reg      <= vz_next;
        zf_reg      <= zf_next;
        theta_reg   <= theta_next;
        ang_reg     <= ang_next;
        rx_reg      <= rx_next;
        ry_reg      <= ry_next;
        rz_reg      <= rz_next;
        rem_reg     <= rem_next;
        q_reg       <= q_next;
        den_reg     <= den_next;
        pos_reg     <= pos_next;
        sat_reg     <= sat_next;
        wa_reg      <= wa_next;
        wb_reg      <= wb_next;
        pra_reg     <= pra_next;
        prb_reg     <= prb_next;
        out_reg     <= out_next;
        lin_out_reg <= side_reg[PRD].linear;
    end

    assign done        = done_reg;
    assign out_x       = out_reg[0];
    assign out_y       = out_reg[1];
    assign out_z       = out_reg[2];
    assign out_w       = out_reg[3];
    assign used_linear = lin_out_reg;

endmodule

[hw/rtl/quaternion_slerp.sv]
// quaternion slerp top level: config port, front end, queue, blend pipeline
//
// a word is accepted at a rising edge where start is high and busy is low;
// it carries two unit quaternions a and b (q2.14) and the blend factor.
// each result appears on out_x/out_y/out_z/out_w and used_linear for one
// cycle with done high; the receiver cannot stall, so results never wait.
// throughput: one word per cycle; the blend pipeline takes a new word every
// cycle and busy only rises if the front-end queue fills, which cannot
// happen in steady flow.
// the path to done runs through the 31-stage isqrt, two 16-stage cordics
// and the 15-stage weight divider.
// linear_threshold sits at byte address 0 of the apb port; write it only
// while no word is in flight.
// reset clears the queue and all pipeline valids and sets the threshold
// to 16302 (0.995); no word is lost or produced by reset release.
module quaternion_slerp (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [qs_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready,
    input  logic                      start,
    output logic                      busy,
    input  logic [15:0]               a_x,
    input  logic [15:0]               a_y,
    input  logic [15:0]               a_z,
    input  logic [15:0]               a_w,
    input  logic [15:0]               b_x,
    input  logic [15:0]               b_y,
    input  logic [15:0]               b_z,
    input  logic [15:0]               b_w,
    input  logic [14:0]               blend,
    output logic                      done,
    output logic [15:0]               out_x,
    output logic [15:0]               out_y,
    output logic [15:0]               out_z,
    output logic [15:0]               out_w,
    output logic                      used_linear
);
    import qs_pkg::*;

    logic [14:0] thr_reg;
    logic        cfg_wr;
    logic        hit_thr;
    logic        accept;
    logic        q_push;
    logic        q_pop;
    qs_item_t    f_item;
    qs_item_t    q_item;
    qs_qstat_t   qstat;

    assign hit_thr = paddr[ADDR_W-1:2] == REG_THR;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign pready  = 1'b1;
    assign prdata  = hit_thr ? {17'd0, thr_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= THR_RESET;
        end
        else if (cfg_wr && hit_thr)
        begin
            thr_reg <= pwdata[14:0];
        end
    end

    // words owned by the front end and the queue must fit the queue
    assign busy   = ({1'b0, qstat.count} + (QCNT_W+1)'(q_push)) >= (QCNT_W+1)'(QD);
    assign accept = start && !busy;
    assign q_pop  = !qstat.empty;

    qs_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .a_x    (a_x),
        .a_y    (a_y),
        .a_z    (a_z),
        .a_w    (a_w),
        .b_x    (b_x),
        .b_y    (b_y),
        .b_z    (b_z),
        .b_w    (b_w),
        .blend  (blend),
        .thr    (thr_reg),
        .push   (q_push),
        .item   (f_item)
    );

    qs_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .item_in  (f_item),
        .pop      (q_pop),
        .item_out (q_item),
        .status   (qstat)
    );

    qs_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_vld      (q_pop),
        .in_item     (q_item),
        .done        (done),
        .out_x       (out_x),
        .out_y       (out_y),
        .out_z       (out_z),
        .out_w       (out_w),
        .used_linear (used_linear)
    );

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !qstat.full)
        else $error("queue written while full");

    a_accept_push: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> q_push)
        else $error("accepted word not pushed by front end");

    a_thr_write: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_wr && hit_thr) |=> thr_reg == $past(pwdata[14:0]))
        else $error("threshold write lost");
`endif

endmodule

[tb/tb_quaternion_slerp.sv]
// testbench for the quaternion slerp block: directed, threshold and random blends
`timescale 1ns / 100ps

module tb_quaternion_slerp;

    import qs_pkg::*;

    localparam int CLK_HALF    = 4;
    localparam int CYCLE_LIMIT = 300000;
    localparam int DRAIN_WAIT  = 120;

    typedef struct packed {
        logic [3:0][15:0] a;
        logic [3:0][15:0] b;
        logic [14:0]      t;
    } slerp_word_t;

    typedef struct packed {
        logic [3:0][15:0] q;
        logic             lin;
    } slerp_res_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        start = 1'b0;
    logic        busy;
    logic [15:0] a_x = '0, a_y = '0, a_z = '0, a_w = '0;
    logic [15:0] b_x = '0, b_y = '0, b_z = '0, b_w = '0;
    logic [14:0] blend = '0;
    logic        done;
    logic [15:0] out_x, out_y, out_z, out_w;
    logic        used_linear;

    logic [14:0] thr_shadow = THR_RESET;
    slerp_res_t  blend_expected[$];
    slerp_res_t  head_res;
    int          mismatches = 0;
    int          cycles = 0;

    quaternion_slerp dut (
        .clk(clk), .rst_n(rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .start(start), .busy(busy),
        .a_x(a_x), .a_y(a_y), .a_z(a_z), .a_w(a_w),
        .b_x(b_x), .b_y(b_y), .b_z(b_z), .b_w(b_w),
        .blend(blend), .done(done),
        .out_x(out_x), .out_y(out_y), .out_z(out_z), .out_w(out_w),
        .used_linear(used_linear)
    );

    always #CLK_HALF clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("tb_quaternion_slerp failed");
            $finish;
        end
    end

    // ---------------- predictor ----------------

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned r;
        longint unsigned bitv;
        begin
            r    = 0;
            bitv = 64'd1 << 62;
            while (bitv > v)
                bitv >>= 2;
            while (bitv != 0)
            begin
                if (v >= r + bitv)
                begin
                    v = v - (r + bitv);
                    r = (r >> 1) + bitv;
                end
                else
                    r >>= 1;
                bitv >>= 2;
            end
            return r;
        end
    endfunction

    // sine scaled by the cordic gain, angle in q30
    function automatic longint sine_gained(longint ang);
        longint x, y, z, dx, dy;
        begin
            x = longint'(1) << 30;
            y = 0;
            z = ang;
            for (int i = 0; i < CORDIC_STEPS; i++)
            begin
                dx = y >>> i;
                dy = x >>> i;
                if (z >= 0)
                begin
                    x = x - dx; y = y + dy; z = z - longint'(atan_q30(5'(i)));
                end
                else
                begin
                    x = x + dx; y = y - dy; z = z + longint'(atan_q30(5'(i)));
                end
            end
            return y;
        end
    endfunction

    function automatic longint arccos_q30(longint d);
        longint x, y, z, dx, dy;
        begin
            x = d;
            z = 0;
            y = longint'(int_sqrt((64'd1 << 60) - longint'(d) * longint'(d)));
            if (y == 0)
                return 0;
            for (int i = 0; i < CORDIC_STEPS; i++)
            begin
                dx = y >>> i;
                dy = x >>> i;
                if (y > 0)
                begin
                    x = x + dx; y = y - dy; z = z + longint'(atan_q30(5'(i)));
                end
                else
                begin
                    x = x - dx; y = y + dy; z = z - longint'(atan_q30(5'(i)));
                end
            end
            if (z < 0)
                z = 0;
            if (z > longint'(HALF_PI_Q30))
                z = longint'(HALF_PI_Q30);
            return z;
        end
    endfunction

    function automatic longint sine_ratio(longint num, longint den);
        longint w;
        begin
            if (num <= 0)
                return 0;
            w = (num <<< FRAC_BITS) / den;
            return (w > (longint'(1) << FRAC_BITS)) ? (longint'(1) << FRAC_BITS) : w;
        end
    endfunction

    function automatic slerp_res_t predict_blend(slerp_word_t wd, logic [14:0] thr);
        longint     av[4];
        longint     bv[4];
        longint     dot, t, wa, wb, theta, s0, pa, pb, acc, r;
        bit         lin;
        slerp_res_t res;
        begin
            dot = 0;
            wa  = 0;
            wb  = 0;
            for (int k = 0; k < 4; k++)
            begin
                av[k] = longint'($signed(wd.a[k]));
                bv[k] = longint'($signed(wd.b[k]));
                dot   = dot + av[k] * bv[k];
            end
            t = longint'(wd.t);
            if (t > 16384)
                t = 16384;
            // take the shorter arc
            if (dot < 0)
            begin
                dot = -dot;
                for (int k = 0; k < 4; k++)
                    av[k] = -av[k];
            end
            if (dot > (longint'(1) << 28))
                dot = longint'(1) << 28;
            lin = dot >= (longint'(thr) << 14);
            if (!lin)
            begin
                theta = arccos_q30(dot * 4);
                s0    = sine_gained(theta);
                if (s0 <= 0)
                    lin = 1'b1;
                else
                begin
                    pa = (theta * (16384 - t)) >> 14;
                    pb = (theta * t) >> 14;
                    wa = sine_ratio(sine_gained(pa), s0);
                    wb = sine_ratio(sine_gained(pb), s0);
                end
            end
            if (lin)
            begin
                wa = longint'(q14_to_w(15'(16384 - t)));
                wb = longint'(q14_to_w(15'(t)));
            end
            for (int k = 0; k < 4; k++)
            begin
                acc = wa * av[k] + wb * bv[k] + ((longint'(1) << FRAC_BITS) >> 1);
                r   = acc >>> FRAC_BITS;
                if (r > 32767)
                    r = 32767;
                if (r < -32768)
                    r = -32768;
                res.q[k] = 16'(r);
            end
            res.lin = lin;
            return res;
        end
    endfunction

    // ---------------- result checking ----------------

    task automatic report_mismatch(string what, longint got, longint want);
        begin
            $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, want);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (blend_expected.size() == 0)
                report_mismatch("unexpected word, used_linear", used_linear, 0);
            else
            begin
                head_res = blend_expected.pop_front();
                if (out_x !== head_res.q[0])
                    report_mismatch("out_x", $signed(out_x), $signed(head_res.q[0]));
                if (out_y !== head_res.q[1])
                    report_mismatch("out_y", $signed(out_y), $signed(head_res.q[1]));
                if (out_z !== head_res.q[2])
                    report_mismatch("out_z", $signed(out_z), $signed(head_res.q[2]));
                if (out_w !== head_res.q[3])
                    report_mismatch("out_w", $signed(out_w), $signed(head_res.q[3]));
                if (used_linear !== head_res.lin)
                    report_mismatch("used_linear", used_linear, head_res.lin);
            end
        end
    end

    // ---------------- drivers ----------------

    task automatic send_word(slerp_word_t wd);
        begin
            a_x <= wd.a[0]; a_y <= wd.a[1]; a_z <= wd.a[2]; a_w <= wd.a[3];
            b_x <= wd.b[0]; b_y <= wd.b[1]; b_z <= wd.b[2]; b_w <= wd.b[3];
            blend <= wd.t;
            start <= 1'b1;
            do
                @(posedge clk);
            while (busy);
            blend_expected.push_back(predict_blend(wd, thr_shadow));
        end
    endtask

    task automatic pause_sender(int n);
        begin
            if (n > 0)
            begin
                start <= 1'b0;
                repeat (n) @(posedge clk);
            end
        end
    endtask

    task automatic wait_drained();
        begin
            start <= 1'b0;
            while (blend_expected.size() != 0)
                @(posedge clk);
            repeat (4) @(posedge clk);
        end
    endtask

    task automatic write_threshold(logic [14:0] value);
        begin
            psel    <= 1'b1;
            penable <= 1'b0;
            pwrite  <= 1'b1;
            paddr   <= ADDR_W'({REG_THR, 2'b00});
            pwdata  <= 32'(value);
            @(posedge clk);
            penable <= 1'b1;
            do
                @(posedge clk);
            while (!pready);
            psel    <= 1'b0;
            penable <= 1'b0;
            pwrite  <= 1'b0;
            thr_shadow = value;
        end
    endtask

    // ---------------- stimulus ----------------

    function automatic logic [15:0] to_q14(real v);
        int r;
        begin
            r = $rtoi(v * 16384.0 + (v >= 0.0 ? 0.5 : -0.5));
            if (r > 16384)
                r = 16384;
            if (r < -16384)
                r = -16384;
            return 16'(r);
        end
    endfunction

    // unit quaternion; near_ref perturbs the reference by up to spread per component
    function automatic logic [3:0][15:0] unit_quat(logic [3:0][15:0] refq, bit near_ref,
                                                 real spread);
        real c[4];
        real n;
        logic [3:0][15:0] q;
        begin
            n = 0.0;
            for (int k = 0; k < 4; k++)
            begin
                c[k] = (real'($urandom_range(0, 65535)) - 32768.0) / 32768.0;
                if (near_ref)
                    c[k] = real'($signed(refq[k])) / 16384.0 + c[k] * spread;
                n = n + c[k] * c[k];
            end
            if (n < 1.0e-6)
            begin
                c[0] = 0.0; c[1] = 0.0; c[2] = 0.0; c[3] = 1.0; n = 1.0;
            end
            n = $sqrt(n);
            for (int k = 0; k < 4; k++)
                q[k] = to_q14(c[k] / n);
            return q;
        end
    endfunction

    function automatic slerp_word_t random_word();
        slerp_word_t wd;
        int          kind;
        real         spread;
        begin
            kind = $urandom_range(0, 9);
            wd.a = unit_quat('0, 1'b0, 0.0);
            spread = ($urandom_range(0, 1) == 1) ? 0.02 : 0.5;
            wd.b = unit_quat(wd.a, kind < 5, spread);
            if (kind == 7 || kind == 8)
            begin
                // raw words reach every bit, including the most negative value
                for (int k = 0; k < 4; k++)
                begin
                    wd.a[k] = 16'($urandom);
                    wd.b[k] = 16'($urandom);
                end
            end
            else if (kind == 9)
            begin
                for (int k = 0; k < 4; k++)
                    wd.b[k] = -wd.a[k] + 16'($urandom_range(0, 200) - 100);
            end
            case ($urandom_range(0, 9))
                0:       wd.t = 15'($urandom);
                1:       wd.t = 15'($urandom_range(0, 1) * 16384);
                default: wd.t = 15'($urandom_range(0, 16384));
            endcase
            return wd;
        end
    endfunction

    task automatic run_bursts(int count);
        int left;
        int burst;
        begin
            left = count;
            while (left > 0)
            begin
                burst = $urandom_range(1, 24);
                for (int i = 0; i < burst && left > 0; i++)
                begin
                    send_word(random_word());
                    left--;
                end
                // some bursts run back to back
                pause_sender(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9));
            end
        end
    endtask

    task automatic test_directed();
        slerp_word_t wd;
        logic [3:0][15:0] ident;
        logic [3:0][15:0] ortho;
        begin
            ident = {16'sd16384, 16'sd0, 16'sd0, 16'sd0};
            ortho = {16'sd0, 16'sd0, 16'sd0, 16'sd16384};
            // identical quaternions, blend ends and blend above one
            wd = '{a: ident, b: ident, t: 15'd0};
            send_word(wd);
            wd.t = 15'd16384; send_word(wd);
            wd.t = 15'd32767; send_word(wd);
            // orthogonal: widest angle
            wd = '{a: ident, b: ortho, t: 15'd8192};
            send_word(wd);
            wd.t = 15'd0;     send_word(wd);
            wd.t = 15'd16384; send_word(wd);
            wd.t = 15'd20000; send_word(wd);
            // opposite: negative dot flips a
            wd = '{a: ident, b: {-16'sd16384, 16'sd0, 16'sd0, 16'sd0}, t: 15'd4096};
            send_word(wd);
            wd = '{a: {16'sd11585, 16'sd0, 16'sd0, 16'sd11585},
                   b: {-16'sd11585, 16'sd0, 16'sd11585, 16'sd0}, t: 15'd12000};
            send_word(wd);
            // most negative components, unnormalized
            wd = '{a: {4{16'h8000}}, b: {4{16'h7fff}}, t: 15'd5000};
            send_word(wd);
            wd = '{a: {4{16'h8000}}, b: {4{16'h8000}}, t: 15'd16384};
            send_word(wd);
            wd = '{a: {4{16'h7fff}}, b: {16'h7fff, 16'h8000, 16'h7fff, 16'h8000},
                   t: 15'd9000};
            send_word(wd);
            // dot at and just under the reset threshold
            wd = '{a: ident, b: {16'sd16302, 16'sd1630, 16'sd0, 16'sd0}, t: 15'd8192};
            send_word(wd);
            wd.b = {16'sd16300, 16'sd1660, 16'sd0, 16'sd0}; send_word(wd);
            // zero vectors
            wd = '{a: '0, b: '0, t: 15'd8192};
            send_word(wd);
            wd = '{a: ident, b: '0, t: 15'd1};
            send_word(wd);
            wait_drained();
        end
    endtask

    task automatic test_threshold();
        logic [14:0] settings[5];
        begin
            settings = '{15'd0, 15'd16384, 15'd32767, 15'd8192, THR_RESET};
            foreach (settings[i])
            begin
                write_threshold(settings[i]);
                run_bursts(40);
                wait_drained();
            end
        end
    endtask

    task automatic test_random();
        begin
            run_bursts(400);
            wait_drained();
        end
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);
        test_directed();
        test_threshold();
        test_random();
        repeat (DRAIN_WAIT) @(posedge clk);
        if (mismatches == 0 && blend_expected.size() == 0)
            $display("tb_quaternion_slerp passed");
        else
            $display("tb_quaternion_slerp failed");
        $finish;
    end

endmodule

[filelist.f]
hw/rtl/qs_pkg.sv
hw/rtl/qs_front.sv
hw/rtl/qs_queue.sv
hw/rtl/qs_back.sv
hw/rtl/quaternion_slerp.sv
tb/tb_quaternion_slerp.sv
